/* design/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Types, constants and character helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChUpperA  = 8'h41;
    localparam logic [7:0] ChUpperF  = 8'h46;
    localparam logic [7:0] ChLowerA  = 8'h61;
    localparam logic [7:0] ChLowerF  = 8'h66;
    localparam logic [7:0] HexTen    = 8'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } t_out_item;

    // One queued command: one to three results. The has and last flags
    // apply to the final result of the command only.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       has;
        logic       last;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= ChZero && c <= ChNine) || (c >= ChUpperA && c <= ChUpperF) ||
               (c >= ChLowerA && c <= ChLowerF);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= ChNine) begin
            v = c - ChZero;
        end else if (c <= ChUpperF) begin
            v = c - ChUpperA + HexTen;
        end else begin
            v = c - ChLowerA + HexTen;
        end
        return v[3:0];
    endfunction

endpackage

/* design/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// Accepts input items, tracks held escape characters and turns each item
// into at most one command of zero to three result bytes.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  upd_pkg::t_in_item i_data,
    input  logic             i_plus_as_space,
    input  logic             i_q_full,
    output logic             o_push,
    output upd_pkg::t_cmd    o_cmd
);

    logic [1:0] r_held_count, n_held_count;
    logic [7:0] r_held_digit, n_held_digit;
    logic       accept;
    logic [7:0] c;
    logic       c_hex;
    logic       c_pct;
    logic [7:0] fresh_byte;
    upd_pkg::t_cmd cmd;
    logic       emit;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign c       = i_data.in_byte;
    assign c_hex   = upd_pkg::is_hex(c);
    assign c_pct   = (c == upd_pkg::ChPercent);
    assign fresh_byte = (c == upd_pkg::ChPlus && i_plus_as_space) ? upd_pkg::ChSpace : c;

    always_comb begin
        cmd          = '0;
        cmd.has      = 1'b1;
        emit         = 1'b0;
        n_held_count = 2'd0;
        n_held_digit = r_held_digit;
        if (i_data.is_end) begin
            emit = 1'b1;
            cmd.last = 1'b1;
            unique case (r_held_count)
                2'd1: begin
                    cmd.cnt   = 2'd1;
                    cmd.byte0 = upd_pkg::ChPercent;
                end
                2'd2: begin
                    cmd.cnt   = 2'd2;
                    cmd.byte0 = upd_pkg::ChPercent;
                    cmd.byte1 = r_held_digit;
                end
                default: begin
                    cmd.cnt = 2'd1;
                    cmd.has = 1'b0;
                end
            endcase
        end else begin
            unique case (r_held_count)
                2'd1: begin
                    if (c_hex) begin
                        n_held_digit = c;
                        n_held_count = 2'd2;
                    end else begin
                        emit      = 1'b1;
                        cmd.byte0 = upd_pkg::ChPercent;
                        cmd.byte1 = fresh_byte;
                        // A second percent sign starts a new escape.
                        cmd.cnt      = c_pct ? 2'd1 : 2'd2;
                        n_held_count = c_pct ? 2'd1 : 2'd0;
                    end
                end
                2'd2: begin
                    emit = 1'b1;
                    if (c_hex) begin
                        cmd.cnt   = 2'd1;
                        cmd.byte0 = {upd_pkg::hex_value(r_held_digit),
                                     upd_pkg::hex_value(c)};
                    end else begin
                        cmd.byte0    = upd_pkg::ChPercent;
                        cmd.byte1    = r_held_digit;
                        cmd.byte2    = fresh_byte;
                        cmd.cnt      = c_pct ? 2'd2 : 2'd3;
                        n_held_count = c_pct ? 2'd1 : 2'd0;
                    end
                end
                default: begin
                    if (c_pct) begin
                        n_held_count = 2'd1;
                    end else begin
                        emit      = 1'b1;
                        cmd.cnt   = 2'd1;
                        cmd.byte0 = fresh_byte;
                    end
                end
            endcase
        end
    end

    assign o_push = accept && emit;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
        end else if (accept) begin
            r_held_count <= n_held_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held_digit <= n_held_digit;
        end
    end

endmodule

/* design/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of commands between the front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int unsigned Depth = upd_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output upd_pkg::t_cmd o_cmd
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    upd_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// Takes commands from the queue and delivers their result bytes one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  upd_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output upd_pkg::t_out_item o_data
);

    upd_pkg::t_cmd      r_cmd;
    logic [1:0]         r_pos;
    logic               r_busy;
    logic               r_out_valid;
    upd_pkg::t_out_item r_out;
    upd_pkg::t_out_item sel;
    logic               can_load;
    logic               fin;

    assign can_load = !r_out_valid || i_ready;
    assign fin      = r_busy && (r_pos == r_cmd.cnt - 2'd1);
    // The next command is taken in the cycle the current one hands over its
    // final result, so one-result commands flow at one per cycle unless stalled.
    assign o_pop    = i_q_valid && (!r_busy || (can_load && fin));

    always_comb begin
        sel = '0;
        unique case (r_pos)
            2'd0:    sel.out_byte = r_cmd.byte0;
            2'd1:    sel.out_byte = r_cmd.byte1;
            default: sel.out_byte = r_cmd.byte2;
        endcase
        sel.has_byte = !fin || r_cmd.has;
        sel.last     = fin && r_cmd.last;
        if (!sel.has_byte) begin
            sel.out_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 2'd0;
        end else begin
            if (can_load) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= 2'd0;
            end else if (can_load && fin) begin
                r_busy <= 1'b0;
            end else if (can_load && r_busy) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (can_load && r_busy) begin
            r_out <= sel;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* design/url_percent_decoder_unit.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Streaming URL percent decoder with optional plus-to-space conversion.
// ----------------------------------------------------------------------------
// One input transaction can be accepted every cycle unless the queue is full,
// and results leave at one per cycle unless the output stalls. An input byte
// gives at most one result in steady decoding; a failed escape gives one to
// three and an end marker with held characters one or two, and the single
// output register then sets the pace, one result per cycle, while a short
// command queue lets the input side run on until it fills. Results go through
// the queue, command and output registers. Config writes are always accepted.
module url_percent_decoder_unit #(
    parameter int unsigned QueueDepth = upd_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  upd_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output upd_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic          r_plus_as_space;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    upd_pkg::t_cmd push_cmd;
    upd_pkg::t_cmd pop_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b1;
        end else if (i_cfg_valid) begin
            r_plus_as_space <= i_cfg_data;
        end
    end

    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data          (i_data),
        .i_plus_as_space (r_plus_as_space),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (push_cmd)
    );

    upd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (pop_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule
